@@ src/tlds_pkg.sv @@
// Shared types and constants for the term list dedupe-and-sort block.
// No dependencies; used by tlds_cell and term_list_dedupe_sort.
`timescale 1ns / 1ps
`default_nettype none

package tlds_pkg;

   localparam int CAPACITY_DEF = 64;
   localparam int TERM_W       = 16;
   localparam int VAL_W        = 15;
   localparam int UCNT_W       = 7;

   typedef struct packed {
      logic signed [TERM_W-1:0] term_value;
      logic                     has_value;
      logic                     list_end;
   } req_type;

   typedef struct packed {
      logic [VAL_W-1:0]  sorted_value;
      logic              run_last;
      logic              list_empty;
      logic [UCNT_W-1:0] unique_count;
      logic              overflowed;
   } rsp_type;

   // a term moving along the chain, or the term a cell holds
   typedef struct packed {
      logic             valid;
      logic [VAL_W-1:0] value;
   } tok_type;

   typedef struct packed {
      logic shift;   // unload: every cell takes its right neighbour's term
   } cell_ctrl_type;

   typedef struct packed {
      logic land;    // incoming term settled in this empty cell
   } cell_stat_type;

endpackage

`default_nettype wire

@@ src/tlds_cell.sv @@
// One cell of the insertion chain: holds one term, passes the larger term on.
// Depends on tlds_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tlds_cell (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire tlds_pkg::cell_ctrl_type ctrl,
   input  wire tlds_pkg::tok_type      tok_in,
   input  wire tlds_pkg::tok_type      next_held,
   output tlds_pkg::tok_type           tok_out,
   output tlds_pkg::tok_type           held,
   output tlds_pkg::cell_stat_type     stat
);
   import tlds_pkg::*;

   tok_type held_ff, held_in;
   tok_type tok_ff, tok_in_nxt;
   logic    land;

   always_comb begin
      held_in    = held_ff;
      tok_in_nxt = '0;
      land       = 1'b0;
      if (ctrl.shift) begin
         held_in = next_held;
      end else if (tok_in.valid) begin
         if (!held_ff.valid) begin
            held_in.valid = 1'b1;
            held_in.value = tok_in.value;
            land          = 1'b1;
         end else if (tok_in.value == held_ff.value) begin
            // duplicate: swallowed here
            tok_in_nxt = '0;
         end else if (tok_in.value < held_ff.value) begin
            held_in.value    = tok_in.value;
            tok_in_nxt.valid = 1'b1;
            tok_in_nxt.value = held_ff.value;
         end else begin
            tok_in_nxt = tok_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff.valid <= 1'b0;
         tok_ff.valid  <= 1'b0;
      end else begin
         held_ff.valid <= held_in.valid;
         tok_ff.valid  <= tok_in_nxt.valid;
      end
      held_ff.value <= held_in.value;
      tok_ff.value  <= tok_in_nxt.value;
   end

   assign tok_out   = tok_ff;
   assign held      = held_ff;
   assign stat.land = land;

endmodule

`default_nettype wire

@@ src/term_list_dedupe_sort.sv @@
// Top level: request intake, insertion chain of tlds_cell, sequencer and result port.
// Depends on tlds_pkg and tlds_cell.
// Sequence: after the list_end request the chain settles, then one result per cycle while rsp_stall is low.
// Throughput: one request per cycle while collecting; the settle and unload phases stall requests.
// Reset: synchronous, active high; clears the chain valid bits, counters and state.
`timescale 1ns / 1ps
`default_nettype none

module term_list_dedupe_sort #(
   parameter int CAPACITY = tlds_pkg::CAPACITY_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire tlds_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output tlds_pkg::rsp_type      rsp_data
);
   import tlds_pkg::*;

   localparam int CNT_W = $clog2(CAPACITY + 1);

   localparam logic [1:0] ST_COLLECT = 2'd0;
   localparam logic [1:0] ST_SETTLE  = 2'd1;
   localparam logic [1:0] ST_EMIT    = 2'd2;

   logic [1:0]       state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;     // requests with a value taken
   logic [CNT_W-1:0] ucnt_ff, ucnt_in;   // terms settled in the chain
   logic [CNT_W-1:0] rem_ff, rem_in;     // results still to go / settle timer
   logic             ovf_ff, ovf_in;

   tok_type          tok [CAPACITY+1];
   tok_type          held [CAPACITY+1];
   cell_ctrl_type    ctrl;
   logic [CAPACITY-1:0] land_vec;
   logic             land_any;
   logic             req_acc, rsp_acc, room, last_rsp;

   assign req_stall = (state_ff != ST_COLLECT);
   assign req_acc   = req_valid && !req_stall;
   assign rsp_valid = (state_ff == ST_EMIT);
   assign rsp_acc   = rsp_valid && !rsp_stall;
   assign room      = (cnt_ff < CNT_W'(CAPACITY));
   assign last_rsp  = (ucnt_ff == '0) || (rem_ff == CNT_W'(1));

   // new term enters the head of the chain; negatives never enter
   always_comb begin
      tok[0].valid = req_acc && req_data.has_value && room && !req_data.term_value[TERM_W-1];
      tok[0].value = req_data.term_value[VAL_W-1:0];
   end

   assign held[CAPACITY] = '0;
   assign ctrl.shift     = rsp_acc;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      cell_stat_type stat;
      tlds_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctrl      (ctrl),
         .tok_in    (tok[i]),
         .next_held (held[i+1]),
         .tok_out   (tok[i+1]),
         .held      (held[i]),
         .stat      (stat)
      );
      assign land_vec[i] = stat.land;
   end

   assign land_any = |land_vec;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      ucnt_in  = ucnt_ff;
      rem_in   = rem_ff;
      ovf_in   = ovf_ff;
      if (land_any) begin
         ucnt_in = ucnt_ff + CNT_W'(1);
      end
      unique case (state_ff)
         ST_COLLECT: begin
            if (req_acc) begin
               if (req_data.has_value) begin
                  if (room) begin
                     cnt_in = cnt_ff + CNT_W'(1);
                  end else begin
                     ovf_in = 1'b1;
                  end
               end
               if (req_data.list_end) begin
                  state_in = ST_SETTLE;
                  rem_in   = CNT_W'(CAPACITY);
               end
            end
         end
         ST_SETTLE: begin
            if (rem_ff == '0) begin
               state_in = ST_EMIT;
               rem_in   = ucnt_ff;
            end else begin
               rem_in = rem_ff - CNT_W'(1);
            end
         end
         ST_EMIT: begin
            if (rsp_acc) begin
               rem_in = rem_ff - CNT_W'(1);
               if (last_rsp) begin
                  state_in = ST_COLLECT;
                  cnt_in   = '0;
                  ucnt_in  = '0;
                  ovf_in   = 1'b0;
               end
            end
         end
         default: begin
            state_in = ST_COLLECT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_COLLECT;
         cnt_ff   <= '0;
         ucnt_ff  <= '0;
         rem_ff   <= '0;
         ovf_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         ucnt_ff  <= ucnt_in;
         rem_ff   <= rem_in;
         ovf_ff   <= ovf_in;
      end
   end

   always_comb begin
      rsp_data.sorted_value = held[0].valid ? held[0].value : '0;
      rsp_data.run_last     = last_rsp;
      rsp_data.list_empty   = (ucnt_ff == '0);
      rsp_data.unique_count = UCNT_W'(ucnt_ff);
      rsp_data.overflowed   = ovf_ff;
   end

   // chain must be quiet before unloading starts
   a_no_land_in_emit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> !land_any)
      else $error("term settled during unload");

   a_no_tail_spill: assert property (@(posedge clock) disable iff (reset)
      !tok[CAPACITY].valid)
      else $error("term fell off the end of the chain");

   a_unique_le_count: assert property (@(posedge clock) disable iff (reset)
      ucnt_ff <= cnt_ff)
      else $error("more unique terms than requests taken");

   a_head_matches_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (held[0].valid == (ucnt_ff != '0)))
      else $error("head cell disagrees with unique count");

endmodule

`default_nettype wire
